/* design/wheel_speed_odometer_unit_assert.svh */
// Assertion macros shared by the wheel speed odometer modules
`ifndef WHEEL_SPEED_ODOMETER_UNIT_ASSERT_SVH
`define WHEEL_SPEED_ODOMETER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define WSO_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wso assertion failed");

// Next-cycle implication, disabled during reset
`define WSO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wso assertion failed");

`endif

/* design/wso_pkg.sv */
// Types and constants shared by the wheel speed odometer modules
`default_nettype none

package wso_pkg;

  // Reset values of the configuration registers and state
  localparam logic [15:0] LOCKOUT_RESET      = 16'd100;
  localparam logic [15:0] STALL_RESET        = 16'd5000;
  localparam logic [23:0] DIST_RESET         = 24'd58709;
  localparam logic [31:0] LAST_TRIGGER_RESET = 32'd1;

  // Speed scale: milliseconds per second
  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

  // Divider geometry: numerator is distance times 1000, denominator a period
  localparam int NUM_W = 34;
  localparam int DEN_W = 32;
  localparam int CNT_W = $clog2(NUM_W);

  // Item queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CFG_LOCKOUT = 2'd0,
    CFG_STALL   = 2'd1,
    CFG_DIST    = 2'd2
  } cfg_index_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_DIV  = 1'b1
  } back_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] now_ms;
    logic [15:0] delta_ms;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* design/wso_front.sv */
// Front end: accepts items, decodes their kind and queues them for the back end
`default_nettype none

module wso_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          kind,
  input  wire logic [31:0]   now_ms,
  input  wire logic [15:0]   delta_ms,
  output logic               q_valid,
  output wso_pkg::cmd_t      q_item,
  input  wire logic          q_pop
);

  wso_pkg::cmd_t                  slots [wso_pkg::QDEPTH];
  logic [wso_pkg::QPTR_W-1:0]     wr_ptr;
  logic [wso_pkg::QPTR_W-1:0]     rd_ptr;
  logic [wso_pkg::QCNT_W-1:0]     count;
  logic                           push;
  wso_pkg::cmd_t                  cmd_in;

  // Classify the incoming item
  always_comb begin
    cmd_in.kind     = (kind == 1'b1) ? wso_pkg::KIND_TICK : wso_pkg::KIND_EDGE;
    cmd_in.now_ms   = now_ms;
    cmd_in.delta_ms = delta_ms;
  end

  assign in_ready = (count != wso_pkg::QCNT_W'(wso_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == wso_pkg::QPTR_W'(wso_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == wso_pkg::QPTR_W'(wso_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`include "wheel_speed_odometer_unit_assert.svh"
  `WSO_ASSERT_NOW(a_no_pop_empty, clk, rst, q_pop, count != '0)
  `WSO_ASSERT_NEXT(a_pop_drains, clk, rst, q_pop && !push, count == $past(count) - 1'b1)

endmodule

`default_nettype wire

/* design/wso_div.sv */
// Restoring serial divider, one quotient bit per cycle
`default_nettype none

module wso_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wso_pkg::div_req_t req,
  output wso_pkg::div_rsp_t      rsp
);

  logic [wso_pkg::DEN_W-1:0] rem;
  logic [wso_pkg::DEN_W-1:0] den;
  logic [wso_pkg::NUM_W-1:0] quot;
  logic [wso_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic                      done;
  logic [wso_pkg::DEN_W:0]   trial;
  logic [wso_pkg::DEN_W:0]   diff;
  logic                      ge;

  // One restoring step
  always_comb begin
    trial = {rem, quot[wso_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
  end

  // Shift in quotient bits and keep the partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      den  <= req.den;
      quot <= req.num;
    end else if (busy) begin
      rem  <= ge ? diff[wso_pkg::DEN_W-1:0] : trial[wso_pkg::DEN_W-1:0];
      quot <= {quot[wso_pkg::NUM_W-2:0], ge};
    end
  end

  // Count steps and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= wso_pkg::CNT_W'(wso_pkg::NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

`include "wheel_speed_odometer_unit_assert.svh"
  `WSO_ASSERT_NOW(a_start_idle, clk, rst, req.start, !busy && !done)
  `WSO_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)

endmodule

`default_nettype wire

/* design/wso_back.sv */
// Back end: configuration, odometer state, speed update and result register
`default_nettype none

module wso_back #(
  parameter int INDICATOR_STEPS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [23:0]       cfg_data,
  input  wire logic              q_valid,
  input  wire wso_pkg::cmd_t     q_item,
  output logic                   q_pop,
  output wso_pkg::div_req_t      div_req,
  input  wire wso_pkg::div_rsp_t div_rsp,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   accepted,
  output logic [31:0]            speed_fps,
  output logic [47:0]            distance_total,
  output logic [31:0]            elapsed_ms,
  output logic [1:0]             indicator
);

  localparam int IND_W = $clog2(INDICATOR_STEPS);

  logic [15:0] lockout_ms;
  logic [15:0] stall_timeout_ms;
  logic [23:0] distance_per_trigger;

  wso_pkg::back_state_t state, state_next;
  logic [31:0]      last_trigger, last_trigger_next;
  logic [31:0]      speed, speed_next;
  logic [47:0]      distance_acc, distance_acc_next;
  logic [31:0]      elapsed_acc, elapsed_acc_next;
  logic [IND_W-1:0] pos, pos_next;
  logic             accepted_next;
  logic             load;
  logic [31:0]      since;

  assign cfg_ready = 1'b1;
  assign since     = q_item.now_ms - last_trigger;

  // Next state and result for the item at the head of the queue
  always_comb begin
    state_next        = state;
    last_trigger_next = last_trigger;
    speed_next        = speed;
    distance_acc_next = distance_acc;
    elapsed_acc_next  = elapsed_acc;
    pos_next          = pos;
    accepted_next     = 1'b0;
    load              = 1'b0;
    q_pop             = 1'b0;
    div_req.start     = 1'b0;
    div_req.num       = wso_pkg::NUM_W'(distance_per_trigger) *
                        wso_pkg::NUM_W'(wso_pkg::MS_PER_SECOND);
    div_req.den       = since;
    unique case (state)
      wso_pkg::B_IDLE: begin
        if (q_valid && (!out_valid || out_ready)) begin
          q_pop = 1'b1;
          if (q_item.kind == wso_pkg::KIND_EDGE) begin
            pos_next = (pos == IND_W'(INDICATOR_STEPS - 1)) ? '0 : pos + 1'b1;
            if (since >= {16'd0, lockout_ms}) begin
              accepted_next     = 1'b1;
              last_trigger_next = q_item.now_ms;
              distance_acc_next = distance_acc + 48'(distance_per_trigger);
              if (since == '0) begin
                speed_next = '1;
                load       = 1'b1;
              end else begin
                div_req.start = 1'b1;
                state_next    = wso_pkg::B_DIV;
              end
            end else begin
              load = 1'b1;
            end
          end else begin
            elapsed_acc_next = elapsed_acc + 32'(q_item.delta_ms);
            if (since > {16'd0, stall_timeout_ms}) begin
              speed_next = '0;
            end
            load = 1'b1;
          end
        end
      end
      wso_pkg::B_DIV: begin
        if (div_rsp.done) begin
          accepted_next = 1'b1;
          speed_next    = (div_rsp.quotient[wso_pkg::NUM_W-1:32] != '0) ? '1 :
                          div_rsp.quotient[31:0];
          load          = 1'b1;
          state_next    = wso_pkg::B_IDLE;
        end
      end
      default: state_next = wso_pkg::B_IDLE;
    endcase
  end

  // Hold configuration, odometer state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms           <= wso_pkg::LOCKOUT_RESET;
      stall_timeout_ms     <= wso_pkg::STALL_RESET;
      distance_per_trigger <= wso_pkg::DIST_RESET;
      state                <= wso_pkg::B_IDLE;
      last_trigger         <= wso_pkg::LAST_TRIGGER_RESET;
      speed                <= '0;
      distance_acc         <= '0;
      elapsed_acc          <= '0;
      pos                  <= '0;
      out_valid            <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (wso_pkg::cfg_index_t'(cfg_index))
          wso_pkg::CFG_LOCKOUT: lockout_ms           <= cfg_data[15:0];
          wso_pkg::CFG_STALL:   stall_timeout_ms     <= cfg_data[15:0];
          wso_pkg::CFG_DIST:    distance_per_trigger <= cfg_data;
          default: ;
        endcase
      end
      state        <= state_next;
      last_trigger <= last_trigger_next;
      speed        <= speed_next;
      distance_acc <= distance_acc_next;
      elapsed_acc  <= elapsed_acc_next;
      pos          <= pos_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (load) begin
      accepted       <= accepted_next;
      speed_fps      <= speed_next;
      distance_total <= distance_acc_next;
      elapsed_ms     <= elapsed_acc_next;
      indicator      <= 2'(pos_next);
    end
  end

`include "wheel_speed_odometer_unit_assert.svh"
  `WSO_ASSERT_NOW(a_pop_slot_free, clk, rst, q_pop, !out_valid || out_ready)
  `WSO_ASSERT_NOW(a_done_in_div, clk, rst, div_rsp.done, state == wso_pkg::B_DIV)

endmodule

`default_nettype wire

/* design/wheel_speed_odometer_unit.sv */
// Wheel speed odometer: top level joining front end, divider and back end
//
// Input channel (in_valid/in_ready): one item per sensor falling edge
// (kind 0) or heartbeat tick (kind 1), with the current millisecond time
// and, for ticks, the milliseconds since the last tick.
// Output channel (out_valid/out_ready): exactly one result item per input
// item, in order, with accepted flag, speed, distance, elapsed time and
// rotation indicator.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 lockout,
// 1 stall timeout, 2 distance per trigger; write only while idle.
// The back end answers a tick or a dropped edge directly; an accepted edge
// waits for the 34-step serial divider computing the speed.
// The back end handles one item at a time, so it takes no new item while
// the divider works, and ticks run at 1 per cycle while out_ready is high.
// A two-entry queue lets input items arrive while the back end divides.
// Reset clears the queue and odometer state, sets the last trigger to 1 and
// loads the register defaults (100, 5000, 58709). When the receiver stalls,
// the result is held and no items are taken; the queue fills, in_ready drops.
`default_nettype none

module wheel_speed_odometer_unit #(
  parameter int INDICATOR_STEPS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] delta_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             accepted,
  output logic [31:0]      speed_fps,
  output logic [47:0]      distance_total,
  output logic [31:0]      elapsed_ms,
  output logic [1:0]       indicator
);

  logic              q_valid;
  logic              q_pop;
  wso_pkg::cmd_t     q_item;
  wso_pkg::div_req_t div_req;
  wso_pkg::div_rsp_t div_rsp;

  wso_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .now_ms   (now_ms),
    .delta_ms (delta_ms),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  wso_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  wso_back #(
    .INDICATOR_STEPS (INDICATOR_STEPS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .speed_fps      (speed_fps),
    .distance_total (distance_total),
    .elapsed_ms     (elapsed_ms),
    .indicator      (indicator)
  );

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the wheel speed odometer unit
`timescale 1ns / 100ps

module testbench;

  localparam int IND_STEPS = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    wso_pkg::kind_t kind;
    logic [31:0]    now;
    logic [15:0]    delta;
  } odo_event_t;

  typedef struct {
    logic        acc;
    logic [31:0] speed;
    logic [47:0] distance;
    logic [31:0] elapsed;
    logic [1:0]  ind;
  } odo_reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [23:0] cfg_data = 24'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [31:0] now_ms = 32'd0;
  logic [15:0] delta_ms = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted;
  logic [31:0] speed_fps;
  logic [47:0] distance_total;
  logic [31:0] elapsed_ms;
  logic [1:0]  indicator;

  // Odometer model state and register copies
  logic [15:0] lock_cfg = wso_pkg::LOCKOUT_RESET;
  logic [15:0] stall_cfg = wso_pkg::STALL_RESET;
  logic [23:0] dist_cfg = wso_pkg::DIST_RESET;
  logic [31:0] last_trig = wso_pkg::LAST_TRIGGER_RESET;
  logic [31:0] speed_now = 32'd0;
  logic [47:0] odo_dist = 48'd0;
  logic [31:0] elapsed_now = 32'd0;
  int          ind_pos = 0;

  odo_event_t   pending_events[$];
  odo_reading_t due_readings[$];
  logic         in_took = 1'b0;
  logic         calm = 1'b0;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;
  int           idle_cycles = 0;
  int           faults = 0;

  wheel_speed_odometer_unit #(
    .INDICATOR_STEPS(IND_STEPS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .now_ms(now_ms),
    .delta_ms(delta_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accepted(accepted),
    .speed_fps(speed_fps),
    .distance_total(distance_total),
    .elapsed_ms(elapsed_ms),
    .indicator(indicator)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the odometer model by one item and return the reading it produces
  function automatic odo_reading_t odo_advance(odo_event_t ev);
    odo_reading_t r;
    logic [31:0] since;
    logic [63:0] num;
    logic [63:0] quot;
    since = ev.now - last_trig;
    r.acc = 1'b0;
    if (ev.kind == wso_pkg::KIND_EDGE) begin
      ind_pos = (ind_pos + 1 >= IND_STEPS) ? 0 : ind_pos + 1;
      if (since >= {16'd0, lock_cfg}) begin
        r.acc = 1'b1;
        last_trig = ev.now;
        num = 64'(dist_cfg) * 64'(wso_pkg::MS_PER_SECOND);
        // zero period and quotients past 32 bits saturate
        if (since == 32'd0) begin
          speed_now = '1;
        end else begin
          quot = num / 64'(since);
          speed_now = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
        end
        odo_dist = odo_dist + 48'(dist_cfg);
      end
    end else begin
      elapsed_now = elapsed_now + 32'(ev.delta);
      if (since > {16'd0, stall_cfg}) begin
        speed_now = 32'd0;
      end
    end
    r.speed = speed_now;
    r.distance = odo_dist;
    r.elapsed = elapsed_now;
    r.ind = 2'(ind_pos);
    return r;
  endfunction

  // Pick an idle stretch: mostly none or short, now and then long
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
      faults++;
    end
  endtask

  // Input driver: hold the item until taken, then idle or present the next one
  always @(negedge clk) begin
    odo_event_t ev;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_took) begin
        gap_left = pick_pause();
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        ev = pending_events.pop_front();
        kind <= ev.kind;
        now_ms <= ev.now;
        delta_ms <= ev.delta;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(3) == 0) ? pick_pause() : 0;
      out_ready <= (stall_left == 0);
    end
  end

  // Monitor: track register writes, predict taken items, check results
  always @(posedge clk) begin
    odo_event_t ev;
    odo_reading_t want;
    logic cfg_fire;
    logic in_fire;
    logic out_fire;
    cfg_fire = !rst && cfg_valid && cfg_ready;
    in_fire = !rst && in_valid && in_ready;
    out_fire = !rst && out_valid && out_ready;
    in_took <= in_fire;
    if (cfg_fire) begin
      case (cfg_index)
        wso_pkg::CFG_LOCKOUT: lock_cfg = cfg_data[15:0];
        wso_pkg::CFG_STALL:   stall_cfg = cfg_data[15:0];
        wso_pkg::CFG_DIST:    dist_cfg = cfg_data;
        default: ;
      endcase
    end
    if (in_fire) begin
      ev.kind = wso_pkg::kind_t'(kind);
      ev.now = now_ms;
      ev.delta = delta_ms;
      due_readings.push_back(odo_advance(ev));
    end
    if (out_fire) begin
      if (due_readings.size() == 0) begin
        $display("%0t unexpected result: expected none actual speed %0h", $time, speed_fps);
        faults++;
      end else begin
        want = due_readings.pop_front();
        check_field("accepted", 64'(want.acc), 64'(accepted));
        check_field("speed_fps", 64'(want.speed), 64'(speed_fps));
        check_field("distance_total", 64'(want.distance), 64'(distance_total));
        check_field("elapsed_ms", 64'(want.elapsed), 64'(elapsed_ms));
        check_field("indicator", 64'(want.ind), 64'(indicator));
      end
    end
    // Watchdog: end the run when nothing moves for too long
    if (rst || cfg_fire || in_fire || out_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_event(input wso_pkg::kind_t k, input logic [31:0] t,
                            input logic [15:0] d);
    odo_event_t ev;
    ev.kind = k;
    ev.now = t;
    ev.delta = d;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued item is taken and every result has come back
  task automatic settle();
    while (pending_events.size() > 0 || in_valid || due_readings.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue a ride: edges spaced around the lockout with some bounce,
  // ticks that probe the stall limit, and a little noise
  task automatic queue_ride(input int n);
    logic [31:0] ride;
    logic [31:0] last_edge;
    logic [31:0] step;
    logic [31:0] lo;
    int unsigned r;
    int unsigned r2;
    ride = $urandom;
    last_edge = ride;
    lo = {16'd0, lock_cfg};
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      r2 = $urandom_range(99);
      if (r < 8) begin
        push_event(wso_pkg::kind_t'($urandom_range(1)), $urandom, 16'($urandom));
      end else if (r < 60) begin
        if (r2 < 15 && lo > 0) begin
          step = $urandom_range(lo - 1);
        end else if (r2 < 22) begin
          step = lo;
        end else begin
          step = lo + $urandom_range(lo + 60);
        end
        ride = ride + step;
        if (step >= lo) begin
          last_edge = ride;
        end
        push_event(wso_pkg::KIND_EDGE, ride, 16'($urandom));
      end else if (r2 < 15) begin
        // land just around the stall limit
        ride = last_edge + {16'd0, stall_cfg} + $urandom_range(2) - 1;
        push_event(wso_pkg::KIND_TICK, ride, 16'($urandom_range(1, 40)));
      end else begin
        step = (r2 < 25) ? $urandom_range(16'hFFFF) : $urandom_range(1, 40);
        ride = ride + step;
        push_event(wso_pkg::KIND_TICK, ride, step[15:0]);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items under the reset registers: wrap of the time
    // difference, lockout boundary, stall boundary, extreme fields
    push_event(wso_pkg::KIND_TICK, 32'd0, 16'd0);
    push_event(wso_pkg::KIND_EDGE, 32'd0, 16'hFFFF);
    push_event(wso_pkg::KIND_EDGE, 32'd50, 16'd0);
    push_event(wso_pkg::KIND_EDGE, 32'd99, 16'd0);
    push_event(wso_pkg::KIND_EDGE, 32'd100, 16'd0);
    push_event(wso_pkg::KIND_TICK, 32'd5100, 16'hFFFF);
    push_event(wso_pkg::KIND_TICK, 32'd5101, 16'd1);
    push_event(wso_pkg::KIND_EDGE, 32'hFFFF_FFFF, 16'd0);
    push_event(wso_pkg::KIND_EDGE, 32'd99, 16'd0);
    settle();

    // Zero lockout and stall with the largest distance: zero period and
    // quotient overflow saturate, a tick right at the stall limit
    write_reg(wso_pkg::CFG_LOCKOUT, 24'hFF0000);
    write_reg(wso_pkg::CFG_STALL, 24'd0);
    write_reg(wso_pkg::CFG_DIST, 24'hFFFFFF);
    push_event(wso_pkg::KIND_EDGE, 32'd1000, 16'd0);
    push_event(wso_pkg::KIND_EDGE, 32'd1000, 16'd0);
    push_event(wso_pkg::KIND_EDGE, 32'd1001, 16'd0);
    push_event(wso_pkg::KIND_EDGE, 32'd1004, 16'd0);
    push_event(wso_pkg::KIND_EDGE, 32'd1008, 16'd0);
    push_event(wso_pkg::KIND_TICK, 32'd1008, 16'd0);
    push_event(wso_pkg::KIND_TICK, 32'd1009, 16'h8000);

    // Random rides over several register settings
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(wso_pkg::CFG_LOCKOUT, {8'($urandom), wso_pkg::LOCKOUT_RESET});
          write_reg(wso_pkg::CFG_STALL, {8'($urandom), wso_pkg::STALL_RESET});
          write_reg(wso_pkg::CFG_DIST, wso_pkg::DIST_RESET);
          write_reg(CFG_UNUSED, 24'($urandom));
        end
        1: begin
          write_reg(wso_pkg::CFG_LOCKOUT, 24'd0);
          write_reg(wso_pkg::CFG_STALL, 24'd0);
          write_reg(wso_pkg::CFG_DIST, 24'hFFFFFF);
        end
        2: begin
          write_reg(wso_pkg::CFG_LOCKOUT, 24'hFFFFFF);
          write_reg(wso_pkg::CFG_STALL, 24'h00FFFF);
          write_reg(wso_pkg::CFG_DIST, 24'd0);
        end
        3: begin
          write_reg(wso_pkg::CFG_LOCKOUT, 24'd1);
          write_reg(wso_pkg::CFG_STALL, 24'd1);
          write_reg(wso_pkg::CFG_DIST, 24'd1);
        end
        default: begin
          write_reg(wso_pkg::CFG_LOCKOUT, {8'($urandom), 16'($urandom_range(0, 300))});
          write_reg(wso_pkg::CFG_STALL, {8'($urandom), 16'($urandom_range(0, 3000))});
          write_reg(wso_pkg::CFG_DIST, 24'($urandom));
        end
      endcase
      calm = (p % 3 == 1);
      queue_ride(94);
    end
    settle();

    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/wso_pkg.sv
design/wso_front.sv
design/wso_div.sv
design/wso_back.sv
design/wheel_speed_odometer_unit.sv
verif/testbench.sv
